[hw/rtl/mts_pkg.sv]
// mts_pkg: types and constants for the max tracking stack.
// Used by mts_ctrl, mts_datapath, the top level and the checker; depends on nothing.
package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int MAX_ENTRY_W = VALUE_W + CNT_W;

    localparam logic       ACT_PUSH     = 1'b0;
    localparam logic       ACT_POP      = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                      action;
        logic signed [VALUE_W-1:0] value;
    } mts_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        logic signed [VALUE_W-1:0] max_value;
        logic                      max_valid;
        logic [1:0]                status;
        logic [CNT_W-1:0]          occupancy;
    } mts_out_t;

    typedef struct packed {
        logic exec;
        logic fetch;
        logic load_out;
    } mts_cmd_t;

    typedef struct packed {
        logic reload;
    } mts_stat_t;

endpackage

[hw/rtl/mts_ram.sv]
// mts_ram: generic single-write, single-read RAM with registered read data.
// No package dependency.
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/mts_ctrl.sv]
// mts_ctrl: sequencer for the max tracking stack; drives the handshakes
// and datapath commands. Depends on mts_pkg.
module mts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output mts_pkg::mts_cmd_t   cmd,
    input  mts_pkg::mts_stat_t  stat
);
    import mts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_DONE  = 3'b100
    } mts_state_t;

    mts_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free     = !out_valid_reg || !out_stall;
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;

    assign cmd.exec     = (state_reg == S_IDLE) && in_valid;
    assign cmd.fetch    = (state_reg == S_FETCH);
    assign cmd.load_out = ((state_reg == S_FETCH) || (state_reg == S_DONE)) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.reload ? S_FETCH : S_DONE;
                end
            end
            S_FETCH:
            begin
                state_next = out_free ? S_IDLE : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/mts_datapath.sv]
// mts_datapath: data and maximum stacks in RAM with cached top entries,
// counts and the result register. Depends on mts_pkg and mts_ram.
module mts_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mts_pkg::mts_in_t    in_item,
    output mts_pkg::mts_out_t   out_item,
    input  mts_pkg::mts_cmd_t   cmd,
    output mts_pkg::mts_stat_t  stat
);
    import mts_pkg::*;

    logic [CNT_W-1:0]          vc_reg, vc_next;
    logic [CNT_W-1:0]          mc_reg, mc_next;
    logic [CNT_W-1:0]          rep_top_reg, rep_top_next;
    logic signed [VALUE_W-1:0] top_val_reg, top_val_next;
    logic signed [VALUE_W-1:0] max_top_reg, max_top_next;
    logic signed [VALUE_W-1:0] popped_reg, popped_next;
    logic [1:0]                status_reg, status_next;
    logic                      drop_reg, drop_next;
    mts_out_t                  out_reg, out_next;

    logic                      is_pop, empty, full, pop_ok, push_ok, eq, gt;

    logic                      d_we;
    logic [ADDR_W-1:0]         d_raddr;
    logic [VALUE_W-1:0]        d_rdata;

    logic                      m_we;
    logic [ADDR_W-1:0]         m_waddr, m_raddr;
    logic [MAX_ENTRY_W-1:0]    m_wdata, m_rdata;

    assign is_pop  = (in_item.action == ACT_POP);
    assign empty   = (vc_reg == '0);
    assign full    = (vc_reg == CNT_W'(STACK_DEPTH));
    assign pop_ok  = is_pop && !empty;
    assign push_ok = !is_pop && !full;
    assign eq      = (in_item.value == max_top_reg);
    assign gt      = (in_item.value > max_top_reg);

    assign stat.reload = pop_ok;

    assign d_we    = cmd.exec && push_ok;
    assign d_raddr = ADDR_W'(vc_reg - CNT_W'(2));
    assign m_raddr = ADDR_W'(mc_reg - CNT_W'(2));

    mts_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (vc_reg[ADDR_W-1:0]),
        .wdata (in_item.value),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    mts_ram #(.WIDTH(MAX_ENTRY_W), .DEPTH(STACK_DEPTH)) u_max_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    always_comb
    begin
        vc_next      = vc_reg;
        mc_next      = mc_reg;
        rep_top_next = rep_top_reg;
        top_val_next = top_val_reg;
        max_top_next = max_top_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        drop_next    = drop_reg;
        m_we         = 1'b0;
        m_waddr      = ADDR_W'(mc_reg - CNT_W'(1));
        m_wdata      = {in_item.value, CNT_W'(1)};

        if (cmd.exec)
        begin
            popped_next = '0;
            status_next = STATUS_OK;
            drop_next   = 1'b0;
            if (!is_pop)
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    vc_next      = vc_reg + CNT_W'(1);
                    top_val_next = in_item.value;
                    priority if (mc_reg == '0)
                    begin
                        m_we         = 1'b1;
                        m_waddr      = '0;
                        mc_next      = CNT_W'(1);
                        max_top_next = in_item.value;
                        rep_top_next = CNT_W'(1);
                    end
                    else if (eq)
                    begin
                        m_we         = 1'b1;
                        m_wdata      = {max_top_reg, rep_top_reg + CNT_W'(1)};
                        rep_top_next = rep_top_reg + CNT_W'(1);
                    end
                    else if (gt)
                    begin
                        m_we         = 1'b1;
                        m_waddr      = mc_reg[ADDR_W-1:0];
                        mc_next      = mc_reg + CNT_W'(1);
                        max_top_next = in_item.value;
                        rep_top_next = CNT_W'(1);
                    end
                    else
                    begin
                        m_we = 1'b0;
                    end
                end
            end
            else if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                vc_next     = vc_reg - CNT_W'(1);
                popped_next = top_val_reg;
                if ((mc_reg != '0) && (top_val_reg == max_top_reg))
                begin
                    if (rep_top_reg <= CNT_W'(1))
                    begin
                        mc_next   = mc_reg - CNT_W'(1);
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        m_we         = 1'b1;
                        m_wdata      = {max_top_reg, rep_top_reg - CNT_W'(1)};
                        rep_top_next = rep_top_reg - CNT_W'(1);
                    end
                end
            end
        end

        if (cmd.fetch)
        begin
            top_val_next = d_rdata;
            if (drop_reg)
            begin
                max_top_next = m_rdata[MAX_ENTRY_W-1:CNT_W];
                rep_top_next = m_rdata[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        out_next              = out_reg;
        if (cmd.load_out)
        begin
            out_next.popped_value = popped_reg;
            out_next.max_valid    = (vc_reg != '0);
            out_next.max_value    = (vc_reg != '0) ? max_top_next : '0;
            out_next.status       = status_reg;
            out_next.occupancy    = vc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= '0;
            mc_reg <= '0;
        end
        else
        begin
            vc_reg <= vc_next;
            mc_reg <= mc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_top_reg <= rep_top_next;
        top_val_reg <= top_val_next;
        max_top_reg <= max_top_next;
        popped_reg  <= popped_next;
        status_reg  <= status_next;
        drop_reg    <= drop_next;
        out_reg     <= out_next;
    end

    assign out_item = out_reg;

endmodule

[hw/rtl/max_tracking_stack_unit.sv]
// max_tracking_stack_unit: top level of the max tracking stack.
// Depends on mts_pkg, mts_ctrl, mts_datapath (and mts_ram below it).
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries one operation per item:
//   action ACT_PUSH pushes value, ACT_POP removes the top value.
//   Output channel out_valid/out_stall/out_item returns exactly one result
//   per item: popped value, current maximum with its valid flag, status
//   (ok, pop on empty, push on full) and occupancy after the operation.
//   The result is loaded into the output register in S_FETCH or S_DONE;
//   no new item is taken before S_IDLE. A successful pop uses S_FETCH to
//   read the new top of the data and maximum stacks back from RAM.
//   The input is stalled while an item is in progress; a finished result
//   waits in the output register, and the next item is accepted meanwhile.
//   If the receiver stalls, the result holds and the following item waits
//   until the output register is free.
//   Reset empties both stacks; RAM contents need no clearing.
module max_tracking_stack_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mts_pkg::mts_in_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output mts_pkg::mts_out_t out_item
);
    import mts_pkg::*;

    mts_cmd_t  cmd;
    mts_stat_t stat;

    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    mts_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

[hw/rtl/mts_checker.sv]
// mts_checker: port-level assertions for max_tracking_stack_unit, bound
// to the top level below. Depends on mts_pkg.
module mts_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input mts_pkg::mts_in_t  in_item,
    input logic              out_valid,
    input logic              out_stall,
    input mts_pkg::mts_out_t out_item
);
    import mts_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.occupancy <= CNT_W'(STACK_DEPTH))
        else $error("occupancy beyond depth");

    a_max_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.max_valid == (out_item.occupancy != '0)) &&
                      (out_item.max_valid || (out_item.max_value == '0)))
        else $error("max flag disagrees with occupancy");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == STATUS_EMPTY) |->
            (out_item.occupancy == '0) && (out_item.popped_value == '0))
        else $error("bad empty-pop result");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == STATUS_FULL) |->
            (out_item.occupancy == CNT_W'(STACK_DEPTH)) && (out_item.popped_value == '0))
        else $error("bad full-push result");

endmodule

bind max_tracking_stack_unit mts_checker u_mts_checker (.*);
